// ----- rtl/core/twpg_pkg.sv -----
// twpg_pkg: shared types and constants of the wipe-transition pattern generator
// no dependencies; imported by the divider, square-root and top-level modules

package twpg_pkg;

    localparam int PROG_W = 20;
    localparam int PROG_MIN = -524288;
    localparam int PROG_MAX = 524287;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [2:0] REG_KIND = 3'd0;
    localparam logic [2:0] REG_ADJUST = 3'd1;
    localparam logic [2:0] REG_REVEAL = 3'd2;
    localparam logic [2:0] REG_REVERSE = 3'd3;
    localparam logic [2:0] REG_WIDTH = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;
    localparam logic [2:0] REG_FRAMES = 3'd6;

    localparam logic [2:0] K_WIPE = 3'd0;
    localparam logic [2:0] K_MIDDLE = 3'd1;
    localparam logic [2:0] K_SQUARE = 3'd2;
    localparam logic [2:0] K_CIRCLE = 3'd3;
    localparam logic [2:0] K_BLINDS = 3'd4;
    localparam logic [2:0] K_CHECKS = 3'd5;

    localparam logic [6:0] ADJ_DOWN = 7'd0;
    localparam logic [6:0] ADJ_UP = 7'd100;
    localparam logic [6:0] ADJ_CHECK_MIN = 7'd2;
    localparam int PCT_SCALE = 100;

    // divide by 100 as multiply and shift, exact for operands below 2**20
    localparam int PCT_RCP = 671089;
    localparam int PCT_SHIFT = 26;

    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic       op;
        logic [9:0] x;
        logic [9:0] y;
    } t_in_item;

    typedef struct packed {
        logic                     palette_index;
        logic signed [PROG_W-1:0] progress;
    } t_out_item;

endpackage

// ----- rtl/core/twpg_div.sv -----
// twpg_div: restoring unsigned divider, one quotient bit per cycle
// depends on twpg_pkg, which it imports directly

module twpg_div
    import twpg_pkg::*;
#(
    parameter int NW = 22,
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);
    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy, r_done;
    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_quo;
    logic [DW-1:0]   r_rem, r_den;
    logic [DW:0]     shifted, diff;
    logic            take;

    assign shifted = {r_rem, r_quo[NW-1]};
    assign take = shifted >= {1'b0, r_den};
    assign diff = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CNTW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], take};
            r_rem <= take ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo = r_quo;
    assign o_rem = r_rem;
endmodule

// ----- rtl/core/twpg_sqrt.sv -----
// twpg_sqrt: bit-serial integer square root, one root bit per cycle
// depends on twpg_pkg, which it imports directly

module twpg_sqrt
    import twpg_pkg::*;
#(
    parameter int RW = 38
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [RW-1:0]   i_rad,
    output logic            o_done,
    output logic [RW/2-1:0] o_root
);
    localparam int QW = RW / 2;
    localparam int CNTW = $clog2(QW + 1);

    logic            r_busy, r_done;
    logic [CNTW-1:0] r_cnt;
    logic [RW-1:0]   r_rad;
    logic [QW:0]     r_rem;
    logic [QW-1:0]   r_root;
    logic [QW+2:0]   rem_sh, trial, diff;
    logic            take;

    assign rem_sh = {r_rem, r_rad[RW-1:RW-2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign take = rem_sh >= trial;
    assign diff = rem_sh - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CNTW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad <= i_rad;
            r_rem <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[RW-3:0], 2'b00};
            r_rem <= take ? diff[QW:0] : rem_sh[QW:0];
            r_root <= {r_root[QW-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ----- rtl/core/transition_wipe_pattern_generator_top.sv -----
// transition_wipe_pattern_generator_top: sequencer, shared multiplier, registers
// depends on twpg_pkg, twpg_div and twpg_sqrt
//
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   i_in_data (t_in_item)
// output    out        o_out_valid / i_out_stall o_out_data (t_out_item)
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// advance: one divide, NW = clog2(MAX_DIM+1)+FRAC_BITS+3 bits wide
// query: slide checks run two divides, circle three multiplies
// first item after reset or a register write first recomputes stripe sizes and
// radius with the serial divider and root
// synchronous active-low reset; o_in_stall is high while an item is in work
// a finished result waits in the output register while the next item is taken

module transition_wipe_pattern_generator_top
    import twpg_pkg::*;
#(
    parameter int MAX_DIM = 1024,
    parameter int FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int VW = (DIM_W > 10) ? DIM_W : 10;
    localparam int NW = DIM_W + FRAC_BITS + 3;
    localparam int DVW = (DIM_W > 17) ? DIM_W : 17;
    localparam int CW = ((NW > PROG_W) ? NW : PROG_W) + 2;
    localparam int MW = (VW > PROG_W) ? VW : PROG_W;
    localparam int AW = 2 * VW + 1;
    localparam int RW = 2 * (DIM_W + FRAC_BITS);
    localparam int QW = RW / 2;
    localparam int LW = AW + 2 * FRAC_BITS;
    localparam int CMPW = (LW > 2 * MW) ? LW : 2 * MW;

    typedef enum logic [16:0] {
        S_IDLE     = 17'h00001,
        S_DRV_MUL  = 17'h00002,
        S_DRV_PCT  = 17'h00004,
        S_DRV_DIVW = 17'h00008,
        S_DRV_DIVH = 17'h00010,
        S_DRV_SQ1  = 17'h00020,
        S_DRV_SQ2  = 17'h00040,
        S_DRV_ROOT = 17'h00080,
        S_ADV_DIV  = 17'h00100,
        S_ADV_UPD  = 17'h00200,
        S_Q_MX     = 17'h00400,
        S_Q_MY     = 17'h00800,
        S_Q_MP     = 17'h01000,
        S_Q_DIVX   = 17'h02000,
        S_Q_DIVY   = 17'h04000,
        S_Q_FIN    = 17'h08000,
        S_OUT      = 17'h10000
    } t_state;

    t_state r_state, n_state;
    logic r_launch, n_launch, r_dirty, n_dirty, r_started, n_started;
    logic r_out_valid, n_out_valid;
    logic [2:0] r_kind, n_kind;
    logic [6:0] r_adjust, n_adjust;
    logic r_reveal, n_reveal, r_reverse, n_reverse;
    logic [10:0] r_width, n_width, r_height, n_height;
    logic [15:0] r_frames, n_frames;
    logic signed [PROG_W-1:0] r_prog, n_prog;
    logic [DIM_W-1:0] r_sp, n_sp, r_ch, n_ch, r_a, n_a, r_remx, n_remx;
    logic [QW-1:0] r_mrad, n_mrad;
    t_in_item r_item, n_item;
    logic [AW-1:0] r_acc, n_acc;
    logic [2*MW-1:0] r_pp, n_pp;
    logic r_qx, n_qx, r_qy, n_qy;
    t_out_item r_res, n_res, r_out_data, n_out_data;

    logic [DIM_W-1:0] w_eff, h_eff, hw, hh, m_half, big;
    logic [15:0] f_eff;
    logic [2:0] k;
    logic [6:0] a_pct;
    logic [VW-1:0] xv, yv, hwv, hhv, dx, dy;
    logic [MW-1:0] mul_a, mul_b;
    logic [2*MW-1:0] mul_p;
    logic [NW-1:0] pct_quo;
    logic div_start, div_done, sqrt_start, sqrt_done, in_div;
    logic [NW-1:0] div_num, div_quo;
    logic [DVW-1:0] div_den, div_rem;
    logic [QW-1:0] sqrt_root;
    logic signed [CW-1:0] one_fx, hw_fx, hh_fx, w_fx, h_fx, m_fx, sp_fx, r_fx, lim_fx;
    logic signed [CW-1:0] p_cur, step_s, p_nx, p_sat, p_q, ip, xs, ys, rem_s, off_s;
    logic on_fg, fg, outside, pal;

    function automatic logic signed [CW-1:0] f_trunc(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] nv;
        nv = -v;
        return (v >= 0) ? (v >>> FRAC_BITS) : -(nv >>> FRAC_BITS);
    endfunction

    function automatic t_state f_post(input logic op, input logic [2:0] kk);
        if (op == OP_ADVANCE) return S_ADV_DIV;
        if (kk == K_CIRCLE) return S_Q_MX;
        if (kk == K_BLINDS || kk == K_CHECKS) return S_Q_DIVX;
        return S_Q_FIN;
    endfunction

    // effective sizes and kind
    always_comb begin
        if (r_width == '0) w_eff = DIM_W'(1);
        else if (32'(r_width) > 32'(MAX_DIM)) w_eff = DIM_W'(MAX_DIM);
        else w_eff = DIM_W'(r_width);
        if (r_height == '0) h_eff = DIM_W'(1);
        else if (32'(r_height) > 32'(MAX_DIM)) h_eff = DIM_W'(MAX_DIM);
        else h_eff = DIM_W'(r_height);
        hw = w_eff >> 1;
        hh = h_eff >> 1;
        m_half = (hw > hh) ? hw : hh;
        big = (w_eff > h_eff) ? w_eff : h_eff;
        f_eff = (r_frames == '0) ? 16'd1 : r_frames;
        k = (r_kind > K_CHECKS) ? K_WIPE : r_kind;
        if (k == K_BLINDS) a_pct = (r_adjust == '0) ? 7'd1 : r_adjust;
        else a_pct = (r_adjust < ADJ_CHECK_MIN) ? ADJ_CHECK_MIN : r_adjust;
        xv = VW'(r_item.x);
        yv = VW'(r_item.y);
        hwv = VW'(hw);
        hhv = VW'(hh);
        dx = (xv > hwv) ? xv - hwv : hwv - xv;
        dy = (yv > hhv) ? yv - hhv : hhv - yv;
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_DRV_MUL: begin
                mul_a = MW'((k == K_CHECKS) ? m_half : hw);
                mul_b = MW'(a_pct);
            end
            S_DRV_PCT: begin
                mul_a = MW'(r_acc);
                mul_b = MW'(PCT_RCP);
            end
            S_DRV_SQ1: begin
                mul_a = MW'(hw);
                mul_b = MW'(hw);
            end
            S_DRV_SQ2: begin
                mul_a = MW'(hh);
                mul_b = MW'(hh);
            end
            S_Q_MX: begin
                mul_a = MW'(dx);
                mul_b = MW'(dx);
            end
            S_Q_MY: begin
                mul_a = MW'(dy);
                mul_b = MW'(dy);
            end
            S_Q_MP: begin
                mul_a = MW'(r_prog[PROG_W-1:0]);
                mul_b = MW'(r_prog[PROG_W-1:0]);
            end
            default: begin
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign pct_quo = NW'(mul_p >> PCT_SHIFT);

    // divider operands
    always_comb begin
        div_num = '0;
        div_den = DVW'(1);
        unique case (r_state)
            S_DRV_DIVW: begin
                div_num = NW'(w_eff);
                div_den = DVW'(r_a);
            end
            S_DRV_DIVH: begin
                div_num = NW'(h_eff);
                div_den = DVW'(r_a);
            end
            S_ADV_DIV: begin
                div_den = DVW'(f_eff);
                unique case (k)
                    K_WIPE: begin
                        if (r_adjust == ADJ_DOWN || r_adjust == ADJ_UP)
                            div_num = NW'(h_eff) << FRAC_BITS;
                        else
                            div_num = NW'(w_eff) << FRAC_BITS;
                    end
                    K_MIDDLE: begin
                        div_num = NW'(w_eff) << FRAC_BITS;
                        div_den = DVW'({f_eff, 1'b0});
                    end
                    K_SQUARE: begin
                        div_num = NW'(big) << FRAC_BITS;
                        div_den = DVW'({f_eff, 1'b0});
                    end
                    K_CIRCLE: div_num = NW'(r_mrad);
                    K_BLINDS: div_num = NW'(r_sp) << FRAC_BITS;
                    default: div_num = NW'(r_sp) << (FRAC_BITS + 1);
                endcase
            end
            S_Q_DIVX: begin
                div_num = NW'(r_item.x);
                div_den = DVW'(r_sp);
            end
            S_Q_DIVY: begin
                div_num = NW'(r_item.y);
                div_den = DVW'(r_ch);
            end
            default: begin
            end
        endcase
    end

    assign in_div = (r_state == S_DRV_DIVW) || (r_state == S_DRV_DIVH) ||
                    (r_state == S_ADV_DIV) || (r_state == S_Q_DIVX) ||
                    (r_state == S_Q_DIVY);
    assign div_start = in_div && !r_launch;
    assign sqrt_start = (r_state == S_DRV_ROOT) && !r_launch;

    twpg_div #(.NW(NW), .DW(DVW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    twpg_sqrt #(.RW(RW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (RW'(r_acc) << (2 * FRAC_BITS)),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // fixed-point views
    always_comb begin
        one_fx = CW'(1) << FRAC_BITS;
        hw_fx = CW'(hw) << FRAC_BITS;
        hh_fx = CW'(hh) << FRAC_BITS;
        w_fx = CW'(w_eff) << FRAC_BITS;
        h_fx = CW'(h_eff) << FRAC_BITS;
        m_fx = CW'(m_half) << FRAC_BITS;
        sp_fx = CW'(r_sp) << FRAC_BITS;
        r_fx = CW'(r_mrad);
        step_s = CW'(div_quo);
        p_q = CW'(r_prog);
    end

    // frame advance
    always_comb begin
        if (r_started) p_cur = CW'(r_prog);
        else if (r_reverse && k == K_MIDDLE) p_cur = hw_fx;
        else if (r_reverse && k == K_SQUARE) p_cur = m_fx;
        else if (r_reverse && k == K_CIRCLE) p_cur = r_fx;
        else p_cur = '0;
        lim_fx = (k == K_MIDDLE) ? hw_fx : m_fx;
        unique case (k)
            K_WIPE: begin
                if (r_adjust == ADJ_DOWN || r_adjust == ADJ_UP) begin
                    p_nx = (r_adjust == ADJ_DOWN) ? p_cur - step_s : p_cur + step_s;
                    if (p_nx >= h_fx) p_nx = h_fx - one_fx;
                end else begin
                    p_nx = p_cur + step_s;
                    if (p_nx >= w_fx) p_nx = w_fx - one_fx;
                end
            end
            K_MIDDLE, K_SQUARE: begin
                if (r_reverse) begin
                    p_nx = p_cur - step_s;
                    if (p_nx < 0) p_nx = '0;
                end else begin
                    p_nx = p_cur + step_s;
                    if (p_nx >= lim_fx) p_nx = lim_fx - one_fx;
                end
            end
            K_CIRCLE: begin
                if (r_reverse) begin
                    p_nx = p_cur - step_s;
                    if (p_nx < 0) p_nx = '0;
                end else begin
                    p_nx = p_cur + step_s;
                    if (p_nx >= r_fx) p_nx = r_fx;
                end
            end
            K_BLINDS: begin
                p_nx = p_cur + step_s;
                if (p_nx >= sp_fx) p_nx = sp_fx;
            end
            default: begin
                p_nx = p_cur + step_s;
                if (p_nx >= (sp_fx <<< 1)) p_nx = sp_fx;
            end
        endcase
        if (p_nx < CW'(PROG_MIN)) p_sat = CW'(PROG_MIN);
        else if (p_nx > CW'(PROG_MAX)) p_sat = CW'(PROG_MAX);
        else p_sat = p_nx;
    end

    // pixel decision
    always_comb begin
        ip = f_trunc(p_q);
        xs = CW'(r_item.x);
        ys = CW'(r_item.y);
        rem_s = CW'(r_remx);
        off_s = rem_s + ((r_qx ^ r_qy) ? CW'(r_sp) : CW'(0));
        outside = (xv >= VW'(w_eff)) || (yv >= VW'(h_eff));
        fg = ~r_reveal;
        unique case (k)
            K_WIPE: begin
                if (r_adjust == ADJ_DOWN) on_fg = ys <= ip;
                else if (r_adjust == ADJ_UP) on_fg = ys < ip;
                else on_fg = xs < ip;
            end
            K_MIDDLE: begin
                on_fg = !(xs < f_trunc(hw_fx - p_q)) && (xs < f_trunc(hw_fx + p_q));
            end
            K_SQUARE: begin
                fg = r_reveal ^ r_reverse;
                on_fg = (xs < f_trunc(hw_fx - p_q)) || (xs > f_trunc(hw_fx + p_q)) ||
                        (ys < f_trunc(hh_fx - p_q)) || (ys > f_trunc(hh_fx + p_q));
            end
            K_CIRCLE: begin
                fg = ~(r_reveal ^ r_reverse);
                on_fg = (p_q > 0) &&
                        ((CMPW'(r_acc) << (2 * FRAC_BITS)) < CMPW'(r_pp));
            end
            K_BLINDS: on_fg = rem_s <= ip;
            default: on_fg = !((off_s <<< FRAC_BITS) < p_q);
        endcase
        pal = outside ? 1'b0 : (on_fg ? fg : ~fg);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_launch = r_launch;
        n_dirty = r_dirty;
        n_started = r_started;
        n_out_valid = r_out_valid;
        n_kind = r_kind;
        n_adjust = r_adjust;
        n_reveal = r_reveal;
        n_reverse = r_reverse;
        n_width = r_width;
        n_height = r_height;
        n_frames = r_frames;
        n_prog = r_prog;
        n_sp = r_sp;
        n_ch = r_ch;
        n_mrad = r_mrad;
        n_item = r_item;
        n_a = r_a;
        n_acc = r_acc;
        n_pp = r_pp;
        n_qx = r_qx;
        n_qy = r_qy;
        n_remx = r_remx;
        n_res = r_res;
        n_out_data = r_out_data;

        if (i_cfg_we) begin
            n_started = 1'b0;
            n_dirty = 1'b1;
            unique case (i_cfg_index)
                REG_KIND: n_kind = i_cfg_data[2:0];
                REG_ADJUST: n_adjust = i_cfg_data[6:0];
                REG_REVEAL: n_reveal = i_cfg_data[0];
                REG_REVERSE: n_reverse = i_cfg_data[0];
                REG_WIDTH: n_width = i_cfg_data[10:0];
                REG_HEIGHT: n_height = i_cfg_data[10:0];
                REG_FRAMES: n_frames = i_cfg_data;
                default: begin
                    n_started = r_started;
                    n_dirty = r_dirty;
                end
            endcase
        end

        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        if (div_start || sqrt_start) n_launch = 1'b1;
        if (div_done || sqrt_done) n_launch = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_data;
                    if (r_dirty) begin
                        n_sp = DIM_W'(1);
                        n_ch = DIM_W'(1);
                        n_state = (k == K_BLINDS || k == K_CHECKS) ? S_DRV_MUL : S_DRV_SQ1;
                    end else begin
                        n_state = f_post(i_in_data.op, k);
                    end
                end
            end
            S_DRV_MUL: begin
                n_acc = AW'(mul_p);
                n_state = S_DRV_PCT;
            end
            S_DRV_PCT: begin
                if (k == K_BLINDS)
                    n_a = (pct_quo == '0) ? DIM_W'(1) : DIM_W'(pct_quo);
                else
                    n_a = (pct_quo < NW'(ADJ_CHECK_MIN)) ? DIM_W'(ADJ_CHECK_MIN) :
                          DIM_W'(pct_quo);
                n_state = S_DRV_DIVW;
            end
            S_DRV_DIVW: begin
                if (div_done) begin
                    n_sp = (div_quo == '0) ? DIM_W'(1) : DIM_W'(div_quo);
                    n_state = (k == K_CHECKS) ? S_DRV_DIVH : S_DRV_SQ1;
                end
            end
            S_DRV_DIVH: begin
                if (div_done) begin
                    n_ch = (div_quo == '0) ? DIM_W'(1) : DIM_W'(div_quo);
                    n_state = S_DRV_SQ1;
                end
            end
            S_DRV_SQ1: begin
                n_acc = AW'(mul_p);
                n_state = S_DRV_SQ2;
            end
            S_DRV_SQ2: begin
                n_acc = r_acc + AW'(mul_p);
                n_state = S_DRV_ROOT;
            end
            S_DRV_ROOT: begin
                if (sqrt_done) begin
                    n_mrad = sqrt_root;
                    n_dirty = 1'b0;
                    n_state = f_post(r_item.op, k);
                end
            end
            S_ADV_DIV: begin
                if (div_done) n_state = S_ADV_UPD;
            end
            S_ADV_UPD: begin
                n_prog = PROG_W'(p_sat);
                n_started = 1'b1;
                n_res.palette_index = 1'b0;
                n_res.progress = PROG_W'(p_sat);
                n_state = S_OUT;
            end
            S_Q_MX: begin
                n_acc = AW'(mul_p);
                n_state = S_Q_MY;
            end
            S_Q_MY: begin
                n_acc = r_acc + AW'(mul_p);
                n_state = S_Q_MP;
            end
            S_Q_MP: begin
                n_pp = mul_p;
                n_state = S_Q_FIN;
            end
            S_Q_DIVX: begin
                if (div_done) begin
                    n_qx = div_quo[0];
                    n_remx = DIM_W'(div_rem);
                    n_state = (k == K_CHECKS) ? S_Q_DIVY : S_Q_FIN;
                end
            end
            S_Q_DIVY: begin
                if (div_done) begin
                    n_qy = div_quo[0];
                    n_state = S_Q_FIN;
                end
            end
            S_Q_FIN: begin
                n_res.palette_index = pal;
                n_res.progress = r_prog;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data = r_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_launch <= 1'b0;
            r_dirty <= 1'b1;
            r_started <= 1'b0;
            r_out_valid <= 1'b0;
            r_kind <= K_WIPE;
            r_adjust <= 7'd50;
            r_reveal <= 1'b1;
            r_reverse <= 1'b0;
            r_width <= 11'd32;
            r_height <= 11'd32;
            r_frames <= 16'd100;
            r_prog <= '0;
            r_sp <= DIM_W'(1);
            r_ch <= DIM_W'(1);
            r_mrad <= '0;
        end else begin
            r_state <= n_state;
            r_launch <= n_launch;
            r_dirty <= n_dirty;
            r_started <= n_started;
            r_out_valid <= n_out_valid;
            r_kind <= n_kind;
            r_adjust <= n_adjust;
            r_reveal <= n_reveal;
            r_reverse <= n_reverse;
            r_width <= n_width;
            r_height <= n_height;
            r_frames <= n_frames;
            r_prog <= n_prog;
            r_sp <= n_sp;
            r_ch <= n_ch;
            r_mrad <= n_mrad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_a <= n_a;
        r_acc <= n_acc;
        r_pp <= n_pp;
        r_qx <= n_qx;
        r_qy <= n_qy;
        r_remx <= n_remx;
        r_res <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted item did not start the sequencer");

    a_result_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result shown without passing the output state");

    a_sizes_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_DIVX) |-> ((r_sp != '0) && (r_ch != '0)))
        else $error("zero stripe period or cell height at a divide");
endmodule
